@@ rtl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and fixed field widths for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int CSR_BITS  = 7;
   localparam int DATA_BITS = 16;

   localparam logic [CSR_BITS-1:0] CSR_LEN_RESET = 7'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_FIND
   } swm_state_type;

   typedef struct packed {
      logic shift;   // new sample enters, probes reload
      logic count;   // probes step one cell and accumulate ranks
      logic rotate;  // probes step one cell, ranks held
   } swm_ctrl_type;

endpackage

@@ rtl/sliding_window_median.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median
// Lower median over the most recent window_len samples of a stream.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata[15:0]  sample
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata[15:0]  median
//   csr      in   csr_wr_en              csr_wr_data[6:0] window_len
//
// A transaction that yields no result leaves req ready. One that yields a
// result makes the probe ring take one full pass through the cell chain, then
// turn past cell 0 until the median shows.
// Synchronous reset clears fill and control; no clearing pass is needed.
// A stalled rsp holds the ring once the median is found; req waits meanwhile.
// ----------------------------------------------------------------------------
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_BITS-1:0]  csr_wr_data,   // window_len
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_BITS-1:0] req_tdata,     // [15:0] sample
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata      // [15:0] median
);

   localparam int VAL_W = (SAMPLE_BITS < DATA_BITS) ? SAMPLE_BITS : DATA_BITS;
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int CMP_W = (LEN_W > CSR_BITS) ? LEN_W : CSR_BITS;
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(WINDOW_MAX);
   localparam logic [LEN_W-1:0] STEP_LAST = LEN_W'(WINDOW_MAX - 1);

   logic [CSR_BITS-1:0] csr_len_ff;
   logic [LEN_W-1:0]    len_eff;
   logic [CMP_W-1:0]    len_ext;
   logic [LEN_W-1:0]    rank;

   swm_state_type    state_ff, state_in;
   logic [LEN_W-1:0] step_ff, step_in;
   logic [LEN_W-1:0] fill_ff, fill_in, fill_sat;
   logic             enough;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_data_ff, rsp_data_in;
   logic             qual;
   logic             capture;
   swm_ctrl_type     ctrl;

   logic [VAL_W-1:0] data_q  [WINDOW_MAX];
   logic [VAL_W-1:0] pval_q  [WINDOW_MAX];
   logic             pwin_q  [WINDOW_MAX];
   logic [LEN_W-1:0] plo_q   [WINDOW_MAX];
   logic [LEN_W-1:0] ple_q   [WINDOW_MAX];

   // window length, clamped to 1..WINDOW_MAX
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_len_ff <= CSR_LEN_RESET;
      end else if (csr_wr_en) begin
         csr_len_ff <= csr_wr_data;
      end
   end

   always_comb begin
      len_ext = CMP_W'(csr_len_ff);
      if (len_ext == '0) begin
         len_ext = CMP_W'(1);
      end else if (len_ext > CMP_W'(WINDOW_MAX)) begin
         len_ext = CMP_W'(WINDOW_MAX);
      end
      len_eff = LEN_W'(len_ext);
   end

   assign rank = LEN_W'(({1'b0, len_eff} + (LEN_W + 1)'(1)) >> 1);

   // cell chain
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [VAL_W-1:0] d_in;
      logic [VAL_W-1:0] pv_in;
      logic             pw_in;
      logic [LEN_W-1:0] pl_in;
      logic [LEN_W-1:0] pe_in;

      if (i == 0) begin : g_head
         assign d_in  = req_tdata[VAL_W-1:0];
         assign pv_in = pval_q[WINDOW_MAX-1];
         assign pw_in = pwin_q[WINDOW_MAX-1];
         assign pl_in = plo_q[WINDOW_MAX-1];
         assign pe_in = ple_q[WINDOW_MAX-1];
      end else begin : g_body
         assign d_in  = data_q[i-1];
         assign pv_in = pval_q[i-1];
         assign pw_in = pwin_q[i-1];
         assign pl_in = plo_q[i-1];
         assign pe_in = ple_q[i-1];
      end

      swm_cell #(
         .INDEX (i),
         .VAL_W (VAL_W),
         .LEN_W (LEN_W)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .len_eff       (len_eff),
         .data_in       (d_in),
         .data_out      (data_q[i]),
         .probe_val_in  (pv_in),
         .probe_win_in  (pw_in),
         .probe_lo_in   (pl_in),
         .probe_le_in   (pe_in),
         .probe_val_out (pval_q[i]),
         .probe_win_out (pwin_q[i]),
         .probe_lo_out  (plo_q[i]),
         .probe_le_out  (ple_q[i])
      );
   end

   assign qual = pwin_q[0] && (plo_q[0] < rank) && (rank <= ple_q[0]);

   assign fill_sat = (fill_ff == LEN_MAX) ? fill_ff : fill_ff + LEN_W'(1);
   assign enough   = fill_sat >= len_eff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && enough) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (step_ff == STEP_LAST) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (capture) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl       = '0;
      req_tready = 1'b0;
      capture    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ctrl.shift = req_tvalid;
         end
         ST_COUNT: begin
            ctrl.count = 1'b1;
         end
         ST_FIND: begin
            capture     = qual && (!rsp_valid_ff || rsp_tready);
            ctrl.rotate = !qual;
         end
         default: ;
      endcase
   end

   always_comb begin
      step_in = '0;
      if (state_ff == ST_COUNT && step_ff != STEP_LAST) begin
         step_in = step_ff + LEN_W'(1);
      end
      fill_in = ctrl.shift ? fill_sat : fill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (capture) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = pval_q[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(rsp_data_ff);

   // checks
   a_count_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT) |=> (state_ff == ST_COUNT || state_ff == ST_FIND))
      else $error("count phase left for an unexpected state");

   a_short_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !enough) |=> req_tready)
      else $error("transaction without result stalled the input");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COUNT) |-> (step_ff == '0))
      else $error("step counter not clear outside count phase");

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_MAX)
      else $error("fill count beyond window depth");

endmodule

@@ rtl/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the window chain: holds one sample of fixed age and one probe
// that circulates round the ring, gathering its rank against each sample.
// ----------------------------------------------------------------------------
module swm_cell
   import swm_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int VAL_W = 16,
   parameter int LEN_W = 7
) (
   input  logic             clock,
   input  swm_ctrl_type     ctrl,
   input  logic [LEN_W-1:0] len_eff,
   input  logic [VAL_W-1:0] data_in,
   output logic [VAL_W-1:0] data_out,
   input  logic [VAL_W-1:0] probe_val_in,
   input  logic             probe_win_in,
   input  logic [LEN_W-1:0] probe_lo_in,
   input  logic [LEN_W-1:0] probe_le_in,
   output logic [VAL_W-1:0] probe_val_out,
   output logic             probe_win_out,
   output logic [LEN_W-1:0] probe_lo_out,
   output logic [LEN_W-1:0] probe_le_out
);

   logic [VAL_W-1:0] sample_ff, sample_in;
   logic [VAL_W-1:0] probe_val_ff, probe_val_in_d;
   logic             probe_win_ff, probe_win_in_d;
   logic [LEN_W-1:0] probe_lo_ff, probe_lo_in_d;
   logic [LEN_W-1:0] probe_le_ff, probe_le_in_d;
   logic             cell_win;
   logic             is_lt;
   logic             is_le;

   assign cell_win = LEN_W'(INDEX) < len_eff;
   assign is_lt    = cell_win && (sample_ff < probe_val_in);
   assign is_le    = cell_win && (sample_ff <= probe_val_in);

   always_comb begin
      sample_in      = sample_ff;
      probe_val_in_d = probe_val_ff;
      probe_win_in_d = probe_win_ff;
      probe_lo_in_d  = probe_lo_ff;
      probe_le_in_d  = probe_le_ff;
      if (ctrl.shift) begin
         sample_in      = data_in;
         probe_val_in_d = data_in;
         probe_win_in_d = cell_win;
         probe_lo_in_d  = '0;
         probe_le_in_d  = '0;
      end else if (ctrl.count) begin
         probe_val_in_d = probe_val_in;
         probe_win_in_d = probe_win_in;
         probe_lo_in_d  = probe_lo_in + LEN_W'(is_lt);
         probe_le_in_d  = probe_le_in + LEN_W'(is_le);
      end else if (ctrl.rotate) begin
         probe_val_in_d = probe_val_in;
         probe_win_in_d = probe_win_in;
         probe_lo_in_d  = probe_lo_in;
         probe_le_in_d  = probe_le_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      probe_val_ff <= probe_val_in_d;
      probe_win_ff <= probe_win_in_d;
      probe_lo_ff  <= probe_lo_in_d;
      probe_le_ff  <= probe_le_in_d;
   end

   assign data_out      = sample_ff;
   assign probe_val_out = probe_val_ff;
   assign probe_win_out = probe_win_ff;
   assign probe_lo_out  = probe_lo_ff;
   assign probe_le_out  = probe_le_ff;

endmodule
